>>> design/hfst_pkg.sv
package hfst_pkg;

  localparam int unsigned PENDING_DEPTH_DEF = 16;
  localparam int unsigned HDR_LEN = 20;
  localparam int unsigned NOTIFY_END = 24;
  localparam int unsigned HOP_PENDING_LIMIT = 3;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [7:0] MAGIC_P = 8'h50;
  localparam logic [7:0] MAGIC_H = 8'h48;
  localparam logic [7:0] PROTO_VERSION = 8'h01;

  localparam logic [1:0] CMD_RX   = 2'd0;
  localparam logic [1:0] CMD_TX   = 2'd1;
  localparam logic [1:0] CMD_HOP  = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;
  localparam logic [1:0] KIND_STATUS  = 2'd3;

  localparam logic [1:0] VERD_OK      = 2'd0;
  localparam logic [1:0] VERD_SHORT   = 2'd1;
  localparam logic [1:0] VERD_MAGIC   = 2'd2;
  localparam logic [1:0] VERD_SESSION = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_SESSION_ID   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ACK_MASK     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ACK_REQ_MASK = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HOP_MASK     = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] tx_flags;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        last_out;
    logic [1:0]  verdict;
    logic [31:0] frame_seq;
    logic [7:0]  frame_flags;
    logic [31:0] frame_epoch;
    logic [31:0] epoch_in_use;
    logic        hop_due;
    logic [4:0]  pending_total;
    logic [31:0] ack_high;
  } out_word_t;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       judge;
    logic       scan;
    logic       hop;
    logic       emit;
    logic       emit_last;
    logic [4:0] emit_idx;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       last;
    logic       has_pay;
    logic       apply;
    logic       ack_hit;
    logic       scan_done;
    logic       out_free;
  } sts_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    case (idx)
      2'd0: magic_byte = MAGIC_P;
      2'd1: magic_byte = MAGIC_H;
      default: magic_byte = PROTO_VERSION;
    endcase
  endfunction

endpackage

>>> design/hfst_ram.sv
module hfst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/hfst_ctrl.sv
module hfst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hfst_pkg::sts_t sts,
  output hfst_pkg::ctl_t ctl
);
  import hfst_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_JUDGE = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_HOP   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic [4:0] n_res;

  always_comb begin
    case (sts.cmd)
      CMD_TX: n_res = 5'(HDR_LEN);
      CMD_RX: n_res = {4'd0, sts.has_pay} + {4'd0, sts.last};
      default: n_res = 5'd1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    ctl = '0;
    ctl.emit_idx = idx_r;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        idx_nxt = '0;
        state_nxt = (sts.cmd == CMD_RX && sts.last) ? S_JUDGE : S_EMIT;
      end
      S_JUDGE: begin
        ctl.judge = 1'b1;
        if (sts.apply && sts.ack_hit) begin
          state_nxt = S_SCAN;
        end else if (sts.apply) begin
          state_nxt = S_HOP;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_HOP;
        end
      end
      S_HOP: begin
        ctl.hop = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (n_res == 5'd0) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          ctl.emit = 1'b1;
          ctl.emit_last = (idx_r == n_res - 5'd1);
          idx_nxt = idx_r + 5'd1;
          if (ctl.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
    end
  end
endmodule

>>> design/hfst_dp.sv
module hfst_dp #(
  parameter int unsigned PENDING_DEPTH = hfst_pkg::PENDING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hfst_pkg::REG_IDX_W-1:0]   cfg_addr,
  input  logic [hfst_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  hfst_pkg::in_word_t               in_data,
  input  hfst_pkg::ctl_t                   ctl,
  output hfst_pkg::sts_t                   sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output hfst_pkg::out_word_t              out_data
);
  import hfst_pkg::*;

  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned AW = $clog2(PENDING_DEPTH);

  logic [63:0] sess_id_r;
  logic [31:0] interval_r;
  logic [7:0]  ack_mask_r, ackreq_mask_r, hop_mask_r;

  in_word_t    item_r;
  logic [4:0]  rx_count_r;
  logic        rx_magic_ok_r;
  logic [63:0] rx_session_r;
  logic [31:0] rx_epoch_r, rx_seq_r, rx_notify_r;
  logic [7:0]  rx_flags_r;
  logic [31:0] epoch_r, seq_next_r, ack_last_r, elapsed_r, tx_seq_r;
  logic [CW-1:0] count_r, scan_i_r, keep_r;
  logic        rd_pend_r, has_pay_r;
  logic [1:0]  verdict_r;
  logic        out_valid_r;
  out_word_t   out_data_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata, ram_q;
  logic          push, keep_hit, scan_more;
  logic [1:0]    verdict_c;
  logic [CW+4:0] count_ext;
  logic [159:0]  hdr_v;
  logic [7:0]    hdr_a [HDR_LEN];
  out_word_t     res;

  hfst_ram #(.WIDTH(32), .DEPTH(PENDING_DEPTH)) u_pend (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(scan_i_r[AW-1:0]), .rdata(ram_q)
  );

  assign push = ctl.exec && item_r.command == CMD_TX &&
                (item_r.tx_flags & ackreq_mask_r) != 8'd0 &&
                count_r < CW'(PENDING_DEPTH);
  assign keep_hit = ctl.scan && rd_pend_r && ram_q > rx_seq_r;
  assign scan_more = scan_i_r < count_r;

  always_comb begin
    ram_we = push || keep_hit;
    ram_waddr = push ? count_r[AW-1:0] : keep_r[AW-1:0];
    ram_wdata = push ? seq_next_r : ram_q;
  end

  always_comb begin
    if (rx_count_r < 5'(HDR_LEN)) begin
      verdict_c = VERD_SHORT;
    end else if (!rx_magic_ok_r) begin
      verdict_c = VERD_MAGIC;
    end else if (rx_session_r != sess_id_r) begin
      verdict_c = VERD_SESSION;
    end else begin
      verdict_c = VERD_OK;
    end
  end

  assign sts.cmd = item_r.command;
  assign sts.last = item_r.last_byte;
  assign sts.has_pay = has_pay_r;
  assign sts.apply = verdict_c == VERD_OK;
  assign sts.ack_hit = (rx_flags_r & ack_mask_r) != 8'd0;
  assign sts.scan_done = !rd_pend_r && !scan_more;
  assign sts.out_free = !out_valid_r || out_ready;

  assign hdr_v = {MAGIC_P, MAGIC_H, PROTO_VERSION, sess_id_r, epoch_r, tx_seq_r,
                  item_r.tx_flags};
  always_comb begin
    for (int k = 0; k < HDR_LEN; k++) begin
      hdr_a[k] = hdr_v[(HDR_LEN - 1 - k) * 8 +: 8];
    end
  end

  assign count_ext = {5'd0, count_r};

  always_comb begin
    res = '0;
    res.last_out = ctl.emit_last;
    res.epoch_in_use = epoch_r;
    res.hop_due = (count_r > CW'(HOP_PENDING_LIMIT)) || (elapsed_r > interval_r);
    res.pending_total = count_ext[4:0];
    res.ack_high = ack_last_r;
    case (item_r.command)
      CMD_TX: begin
        res.kind = KIND_TX;
        res.out_byte = hdr_a[ctl.emit_idx];
      end
      CMD_RX: begin
        if (has_pay_r && ctl.emit_idx == 5'd0) begin
          res.kind = KIND_PAYLOAD;
          res.out_byte = item_r.data_byte;
        end else begin
          res.kind = KIND_VERDICT;
          res.verdict = verdict_r;
          res.frame_seq = rx_seq_r;
          res.frame_flags = rx_flags_r;
          res.frame_epoch = rx_epoch_r;
        end
      end
      default: res.kind = KIND_STATUS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
    end
    if (ctl.judge) begin
      verdict_r <= verdict_c;
    end
    if (ctl.emit) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_id_r <= '0;
      interval_r <= 32'd30;
      ack_mask_r <= 8'd1;
      ackreq_mask_r <= 8'd2;
      hop_mask_r <= 8'd4;
      rx_count_r <= '0;
      rx_magic_ok_r <= 1'b1;
      rx_session_r <= '0;
      rx_epoch_r <= '0;
      rx_seq_r <= '0;
      rx_flags_r <= '0;
      rx_notify_r <= '0;
      epoch_r <= '0;
      seq_next_r <= '0;
      ack_last_r <= '0;
      elapsed_r <= '0;
      tx_seq_r <= '0;
      count_r <= '0;
      scan_i_r <= '0;
      keep_r <= '0;
      rd_pend_r <= 1'b0;
      has_pay_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SESSION_ID:   sess_id_r <= cfg_wdata;
          REG_INTERVAL:     interval_r <= cfg_wdata[31:0];
          REG_ACK_MASK:     ack_mask_r <= cfg_wdata[7:0];
          REG_ACK_REQ_MASK: ackreq_mask_r <= cfg_wdata[7:0];
          REG_HOP_MASK:     hop_mask_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end

      if (ctl.exec) begin
        case (item_r.command)
          CMD_RX: begin
            has_pay_r <= rx_count_r >= 5'(HDR_LEN);
            if (rx_count_r < 5'd3) begin
              if (item_r.data_byte != magic_byte(rx_count_r[1:0])) begin
                rx_magic_ok_r <= 1'b0;
              end
            end else if (rx_count_r < 5'd11) begin
              rx_session_r <= {rx_session_r[55:0], item_r.data_byte};
            end else if (rx_count_r < 5'd15) begin
              rx_epoch_r <= {rx_epoch_r[23:0], item_r.data_byte};
            end else if (rx_count_r < 5'd19) begin
              rx_seq_r <= {rx_seq_r[23:0], item_r.data_byte};
            end else if (rx_count_r == 5'd19) begin
              rx_flags_r <= item_r.data_byte;
            end else if (rx_count_r < 5'(NOTIFY_END)) begin
              rx_notify_r <= {rx_notify_r[23:0], item_r.data_byte};
            end
            if (rx_count_r < 5'(NOTIFY_END)) begin
              rx_count_r <= rx_count_r + 5'd1;
            end
          end
          CMD_TX: begin
            tx_seq_r <= seq_next_r;
            seq_next_r <= seq_next_r + 32'd1;
            if (push) begin
              count_r <= count_r + CW'(1);
            end
          end
          CMD_HOP: begin
            epoch_r <= epoch_r + 32'd1;
            elapsed_r <= '0;
            count_r <= '0;
          end
          default: begin
            if (elapsed_r != 32'hFFFF_FFFF) begin
              elapsed_r <= elapsed_r + 32'd1;
            end
          end
        endcase
      end

      if (ctl.judge && sts.apply && sts.ack_hit) begin
        if (rx_seq_r > ack_last_r || ack_last_r == 32'd0) begin
          ack_last_r <= rx_seq_r;
        end
        scan_i_r <= '0;
        keep_r <= '0;
        rd_pend_r <= 1'b0;
      end

      if (ctl.scan) begin
        rd_pend_r <= scan_more;
        if (scan_more) begin
          scan_i_r <= scan_i_r + CW'(1);
        end
        if (keep_hit) begin
          keep_r <= keep_r + CW'(1);
        end
        if (sts.scan_done) begin
          count_r <= keep_r;
        end
      end

      if (ctl.hop) begin
        if ((rx_flags_r & hop_mask_r) != 8'd0 && rx_count_r >= 5'(NOTIFY_END) &&
            rx_notify_r > epoch_r) begin
          epoch_r <= rx_notify_r;
          elapsed_r <= '0;
          count_r <= '0;
        end
      end

      if (ctl.emit && ctl.emit_last && item_r.command == CMD_RX && item_r.last_byte) begin
        rx_count_r <= '0;
        rx_magic_ok_r <= 1'b1;
        rx_session_r <= '0;
        rx_epoch_r <= '0;
        rx_seq_r <= '0;
        rx_flags_r <= '0;
        rx_notify_r <= '0;
      end

      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
endmodule

>>> design/hop_frame_session_tracker.sv
// Session tracker for a hop frame protocol with a 20-byte header.
// Input channel (in_valid/in_ready/in_data): one command word, a received
// byte, a send-header request, a hop or a one-second tick.
// Output channel (out_valid/out_ready/out_data): the result words of that
// command, the final one flagged by last_out. A send gives 20 header words,
// a received byte gives zero to two words, hop and tick give one status word.
// Config port (cfg_we/cfg_addr/cfg_wdata): register writes, applied while cfg_we is high.
// One command is processed at a time. Each command is loaded and executed;
// the last byte of a frame is then judged, an accepted frame that carries
// an ACK flag walks the unacked queue memory (one read per cycle), and every
// accepted frame passes a hop step before its results are emitted. Further
// results follow at one per cycle while the receiver takes them.
// Synchronous reset clears the session state, loads register defaults and
// empties the queue; no clearing pass is needed.
// A stalled receiver holds the output register and the block waits; the
// next command is taken once the last result is in the output register.
module hop_frame_session_tracker #(
  parameter int unsigned PENDING_DEPTH = hfst_pkg::PENDING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  hfst_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hfst_pkg::out_word_t              out_data,
  input  logic                             cfg_we,
  input  logic [hfst_pkg::REG_IDX_W-1:0]   cfg_addr,
  input  logic [hfst_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import hfst_pkg::*;

  ctl_t ctl;
  sts_t sts;

  hfst_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .ctl(ctl)
  );

  hfst_dp #(.PENDING_DEPTH(PENDING_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .in_data(in_data), .ctl(ctl), .sts(sts),
    .out_ready(out_ready), .out_valid(out_valid), .out_data(out_data)
  );

`ifndef ASSERT_OFF
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_VERDICT |-> out_data.last_out)
    else $error("verdict not final result");
  a_verdict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_VERDICT |-> out_data.verdict == VERD_OK)
    else $error("verdict on non-verdict word");
`endif
endmodule
